FILE: rtl/assert_macros.svh
// Assertion helpers shared by the console writer modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("console writer assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("console writer assertion failed");

`endif

FILE: rtl/tccw_pkg.sv
package tccw_pkg;

  localparam int SCREEN_COLUMNS = 80;
  localparam int SCREEN_ROWS    = 25;
  localparam int TAB_STEP       = 4;

  localparam int COL_W   = 7;
  localparam int ROW_W   = 5;
  localparam int CELL_W  = 11;
  localparam int DIGIT_DEPTH = 10;
  localparam int NDIG_W  = 4;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = 2;

  localparam logic [7:0] ATTR_RESET = 8'hD0;
  localparam logic [7:0] CH_NEWLINE = 8'd10;
  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_MINUS   = 8'h2D;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_DEC  = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  // Reciprocal of ten, scaled by 2^35: exact quotient for every 32-bit value.
  localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

  typedef enum logic [2:0] {
    F_IDLE,
    F_CHAR,
    F_MUL,
    F_DIV,
    F_SIGN,
    F_DIGITS
  } front_state_t;

  // One character handed from the front part to the back part.
  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } queue_entry_t;

endpackage

FILE: rtl/text_console_cell_writer_unit.sv
// Text console cell writer for an 80 by 25 cell text screen.
// Input channel (in_valid/in_ready) carries one console item per transfer:
// kind selects a plain character (char_code), a signed decimal number or a
// signed hexadecimal number (number). Output channel (out_valid/out_ready)
// carries one transfer per emitted character: a cell write or a cursor move,
// with last set on the final character of the item. An unused kind is taken
// and dropped without any output.
// A plain character is registered in the front, written into the queue and
// then popped into the output register. A number is first split into digits,
// each decimal digit by a reciprocal multiply and then a remainder step, each
// hex digit by a shift step, and then one character per cycle is queued while
// the queue has room; the front accepts a new item once the last character of
// the current one is queued.
// A four-entry character queue parts the digit front from the cursor back;
// when the receiver stalls, the back holds its output register, the queue
// fills and the front waits with in_ready low. Reset clears the cursor, the
// queue and out_valid and sets the attribute register to 0xD0.
// The attribute register sits at APB address 0; the user must write it only
// while the block is idle, which the block itself does not enforce.

module text_console_cell_writer_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [1:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         kind,
  input  logic [7:0]         char_code,
  input  logic signed [31:0] number,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               do_write,
  output logic [10:0]        cell_index,
  output logic [7:0]         glyph,
  output logic [7:0]         attribute,
  output logic               clear_screen,
  output logic               last
);
  import tccw_pkg::*;

  logic [7:0]   text_attribute;
  logic         push;
  logic         pop;
  logic         queue_full;
  logic         queue_empty;
  queue_entry_t push_entry;
  queue_entry_t head;

  // Single register: every write transfer lands in the attribute byte.
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? {24'd0, text_attribute} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_attribute <= ATTR_RESET;
    end else if (psel && penable && pwrite && pready) begin
      text_attribute <= pwdata[7:0];
    end
  end

  // Front: takes items and turns numbers into sign and digit characters.
  tccw_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .kind       (kind),
    .char_code  (char_code),
    .number     (number),
    .push       (push),
    .push_entry (push_entry),
    .queue_full (queue_full)
  );

  tccw_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head       (head),
    .empty      (queue_empty)
  );

  // Back: moves the cursor and produces one result per character.
  tccw_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head           (head),
    .empty          (queue_empty),
    .pop            (pop),
    .text_attribute (text_attribute),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .do_write       (do_write),
    .cell_index     (cell_index),
    .glyph          (glyph),
    .attribute      (attribute),
    .clear_screen   (clear_screen),
    .last           (last)
  );

endmodule

FILE: rtl/tccw_front.sv
`include "assert_macros.svh"

module tccw_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            kind,
  input  logic [7:0]            char_code,
  input  logic signed [31:0]    number,
  output logic                  push,
  output tccw_pkg::queue_entry_t push_entry,
  input  logic                  queue_full
);
  import tccw_pkg::*;

  front_state_t state, state_next;
  logic              is_dec;
  logic              neg;
  logic [31:0]       mag;
  logic [63:0]       prod;
  logic [NDIG_W-1:0] ndig;
  logic [7:0]        ch;
  logic [3:0]        digit_store [DIGIT_DEPTH];

  logic [31:0] quot;
  logic [3:0]  rem_digit;
  logic        extract_done;
  logic [3:0]  cur_digit;
  logic        accept;

  function automatic logic [7:0] digit_char(input logic [3:0] d);
    if (d > 4'd9) begin
      return 8'h41 + {4'd0, d} - 8'd10;
    end
    return 8'h30 + {4'd0, d};
  endfunction

  assign accept = in_valid && in_ready;

  // Decimal digit: quotient from the registered reciprocal product; hex digit: shift and low nibble.
  always_comb begin
    if (is_dec) begin
      quot      = {3'd0, prod[63:35]};
      rem_digit = 4'(mag - ((quot << 3) + (quot << 1)));
    end else begin
      quot      = {4'd0, mag[31:4]};
      rem_digit = mag[3:0];
    end
    extract_done = (quot == 32'd0) || (ndig == NDIG_W'(DIGIT_DEPTH - 1));
    cur_digit    = digit_store[ndig - NDIG_W'(1)];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      F_IDLE: begin
        if (accept) begin
          if (kind == KIND_CHAR) begin
            state_next = F_CHAR;
          end else if (kind == KIND_DEC) begin
            state_next = F_MUL;
          end else if (kind == KIND_HEX) begin
            state_next = F_DIV;
          end
        end
      end
      F_CHAR: begin
        if (!queue_full) state_next = F_IDLE;
      end
      F_MUL: state_next = F_DIV;
      F_DIV: begin
        if (extract_done) begin
          state_next = F_SIGN;
        end else if (is_dec) begin
          state_next = F_MUL;
        end
      end
      F_SIGN: begin
        if (!neg || !queue_full) state_next = F_DIGITS;
      end
      F_DIGITS: begin
        if (!queue_full && ndig == NDIG_W'(1)) state_next = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  always_comb begin
    in_ready   = (state == F_IDLE);
    push       = 1'b0;
    push_entry = '{ch: 8'd0, last: 1'b0};
    unique case (state)
      F_CHAR: begin
        push       = !queue_full;
        push_entry = '{ch: ch, last: 1'b1};
      end
      F_SIGN: begin
        push       = neg && !queue_full;
        push_entry = '{ch: CH_MINUS, last: 1'b0};
      end
      F_DIGITS: begin
        push       = !queue_full;
        push_entry = '{ch: digit_char(cur_digit), last: (ndig == NDIG_W'(1))};
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      ndig  <= '0;
    end else begin
      state <= state_next;
      if (state == F_IDLE && accept) begin
        ndig <= '0;
      end else if (state == F_DIV) begin
        ndig <= ndig + NDIG_W'(1);
      end else if (state == F_DIGITS && !queue_full) begin
        ndig <= ndig - NDIG_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == F_IDLE && accept) begin
      ch     <= char_code;
      is_dec <= (kind == KIND_DEC);
      neg    <= number[31];
      mag    <= number[31] ? (32'd0 - $unsigned(number)) : $unsigned(number);
    end
    if (state == F_MUL) begin
      prod <= mag * RECIP_TEN;
    end
    if (state == F_DIV) begin
      digit_store[ndig] <= rem_digit;
      mag               <= quot;
    end
  end

  `ASSERT_IMPLIES(a_ndig_range, clk, rst, 1'b1, ndig <= NDIG_W'(DIGIT_DEPTH))
  `ASSERT_IMPLIES(a_digits_nonempty, clk, rst, state == F_DIGITS, ndig != '0)

endmodule

FILE: rtl/tccw_queue.sv
`include "assert_macros.svh"

module tccw_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  tccw_pkg::queue_entry_t push_entry,
  output logic                   full,
  input  logic                   pop,
  output tccw_pkg::queue_entry_t head,
  output logic                   empty
);
  import tccw_pkg::*;

  queue_entry_t          slots [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr;
  logic [QUEUE_AW-1:0]   rd_ptr;
  logic [QUEUE_AW:0]     count;

  assign full  = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_AW'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_AW'(1);
      if (push && !pop) begin
        count <= count + (QUEUE_AW + 1)'(1);
      end else if (pop && !push) begin
        count <= count - (QUEUE_AW + 1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_entry;
  end

  `ASSERT_IMPLIES(a_no_overflow, clk, rst, push, !full)
  `ASSERT_IMPLIES(a_no_underflow, clk, rst, pop, !empty)

endmodule

FILE: rtl/tccw_back.sv
`include "assert_macros.svh"

module tccw_back (
  input  logic                   clk,
  input  logic                   rst,
  input  tccw_pkg::queue_entry_t head,
  input  logic                   empty,
  output logic                   pop,
  input  logic [7:0]             text_attribute,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   do_write,
  output logic [10:0]            cell_index,
  output logic [7:0]             glyph,
  output logic [7:0]             attribute,
  output logic                   clear_screen,
  output logic                   last
);
  import tccw_pkg::*;

  logic [COL_W-1:0] cursor_column;
  logic [ROW_W-1:0] cursor_row;

  logic [COL_W:0]   col_n;
  logic [ROW_W:0]   row_n;
  logic             wr_n;
  logic             clr_n;
  logic [11:0]      cell_full;
  logic [CELL_W-1:0] cell_n;
  logic [7:0]       glyph_n;
  logic [7:0]       attr_n;

  assign pop = !empty && (!out_valid || out_ready);

  always_comb begin
    col_n     = {1'b0, cursor_column};
    row_n     = {1'b0, cursor_row};
    wr_n      = 1'b0;
    clr_n     = 1'b0;
    cell_full = 12'(cursor_row) * 12'(SCREEN_COLUMNS) + 12'(cursor_column);
    cell_n    = '0;
    glyph_n   = 8'd0;
    attr_n    = 8'd0;
    case (head.ch)
      CH_NEWLINE: begin
        col_n = '0;
        row_n = row_n + (ROW_W + 1)'(1);
      end
      CH_TAB: begin
        col_n = col_n + (COL_W + 1)'(TAB_STEP);
      end
      default: begin
        wr_n    = 1'b1;
        cell_n  = cell_full[CELL_W-1:0];
        glyph_n = head.ch;
        attr_n  = text_attribute;
        col_n   = col_n + (COL_W + 1)'(1);
      end
    endcase
    if (col_n >= (COL_W + 1)'(SCREEN_COLUMNS)) begin
      col_n = '0;
      row_n = row_n + (ROW_W + 1)'(1);
    end
    if (row_n >= (ROW_W + 1)'(SCREEN_ROWS)) begin
      row_n = '0;
      clr_n = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid     <= 1'b0;
      cursor_column <= '0;
      cursor_row    <= '0;
    end else begin
      if (pop) begin
        out_valid     <= 1'b1;
        cursor_column <= col_n[COL_W-1:0];
        cursor_row    <= row_n[ROW_W-1:0];
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      do_write     <= wr_n;
      cell_index   <= cell_n;
      glyph        <= glyph_n;
      attribute    <= attr_n;
      clear_screen <= clr_n;
      last         <= head.last;
    end
  end

  `ASSERT_IMPLIES(a_col_range, clk, rst, 1'b1, cursor_column < COL_W'(SCREEN_COLUMNS))
  `ASSERT_NEXT(a_row_range, clk, rst, pop, 32'(cursor_row) < SCREEN_ROWS)

endmodule

FILE: tb/tb_text_console_cell_writer_unit.sv
`timescale 1ns / 100ps

module tb_text_console_cell_writer_unit;
  import tccw_pkg::*;

  // Kind code that the block takes and drops without any output.
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  // Register map of the configuration port.
  localparam logic [1:0] REG_TEXT_ATTRIBUTE = 2'd0;

  localparam logic [7:0] ASCII_ZERO    = 8'h30;
  localparam logic [7:0] ASCII_UPPER_A = 8'h41;

  // Waiting this many quiet cycles after the last result outlasts the longest
  // item in the digit front, so the block is idle by the end of the wait.
  localparam int IDLE_SETTLE_CYCLES = 48;

  // Worst correct case: eleven results per item, each held up by the longest
  // receiver stall, plus settle pauses. This limit is far above that.
  localparam int QUIET_LIMIT = 4000;

  localparam int MAX_REPORT_LINES = 100;

  // One expected output transfer: a cell write or a cursor move.
  typedef struct packed {
    logic        do_write;
    logic [10:0] cell_index;
    logic [7:0]  glyph;
    logic [7:0]  attribute;
    logic        clear_screen;
    logic        last;
  } cell_event_t;

  logic               clk;
  logic               rst;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [1:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid;
  logic               in_ready;
  logic [1:0]         kind;
  logic [7:0]         char_code;
  logic signed [31:0] number;
  logic               out_valid;
  logic               out_ready = 1'b1;
  logic               do_write;
  logic [10:0]        cell_index;
  logic [7:0]         glyph;
  logic [7:0]         attribute;
  logic               clear_screen;
  logic               last;

  // Expected output transfers, oldest first, and the predictor's own copy of
  // the cursor and the attribute register.
  cell_event_t expected_cells[$];
  int unsigned cursor_col;
  int unsigned cursor_row;
  logic [7:0]  attr_shadow;

  int mismatch_count = 0;
  int results_checked = 0;
  int quiet_cycles = 0;

  // Sender burst bookkeeping and the receiver's stall pattern state.
  int burst_left = 0;
  int rx_mode = 0;
  int rx_mode_left = 0;
  int rx_hold = 0;
  bit rx_low = 1'b0;
  int unsigned rx_tick = 0;

  text_console_cell_writer_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .kind         (kind),
    .char_code    (char_code),
    .number       (number),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .do_write     (do_write),
    .cell_index   (cell_index),
    .glyph        (glyph),
    .attribute    (attribute),
    .clear_screen (clear_screen),
    .last         (last)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Every mismatch goes through here. Printing is capped so that a badly
  // broken block cannot flood the log, but every mismatch is still counted.
  task automatic report_mismatch(input string what, input longint unsigned got,
                                 input longint unsigned want);
    if (mismatch_count < MAX_REPORT_LINES) begin
      $display("%0t: mismatch at result %0d: %s got 0x%0h, expected 0x%0h",
               $realtime, results_checked, what, got, want);
    end
    mismatch_count++;
  endtask

  // Handles one character against the cursor, exactly as the block's back
  // end does, and queues the output transfer that it causes.
  function automatic void place_character(input logic [7:0] ch, input bit is_last);
    cell_event_t ev;
    ev = '0;
    if (ch == CH_NEWLINE) begin
      cursor_col = 0;
      cursor_row++;
    end else if (ch == CH_TAB) begin
      cursor_col += TAB_STEP;
    end else begin
      ev.do_write   = 1'b1;
      ev.cell_index = 11'(cursor_row * SCREEN_COLUMNS + cursor_col);
      ev.glyph      = ch;
      ev.attribute  = attr_shadow;
      cursor_col++;
    end
    // Running past the row end wraps, and running past the last row clears
    // the screen and returns to the top.
    if (cursor_col >= SCREEN_COLUMNS) begin
      cursor_col = 0;
      cursor_row++;
    end
    if (cursor_row >= SCREEN_ROWS) begin
      cursor_row = 0;
      ev.clear_screen = 1'b1;
    end
    ev.last = is_last;
    expected_cells.push_back(ev);
  endfunction

  // Works out every output transfer that one accepted console item causes.
  function automatic void predict_cell_events(input logic [1:0] k, input logic [7:0] ch,
                                              input logic [31:0] value);
    logic [3:0]  digits [DIGIT_DEPTH];
    logic [31:0] magnitude;
    int unsigned radix;
    int          ndigits;
    bit          negative;
    logic [7:0]  digit_char;
    if (k == KIND_CHAR) begin
      place_character(ch, 1'b1);
    end else if (k == KIND_DEC || k == KIND_HEX) begin
      radix = (k == KIND_DEC) ? 10 : 16;
      negative = value[31];
      // The most negative value wraps back onto itself here, which is the
      // unsigned magnitude that is wanted.
      magnitude = negative ? (32'd0 - value) : value;
      ndigits = 0;
      do begin
        digits[ndigits] = 4'(magnitude % radix);
        ndigits++;
        magnitude = magnitude / radix;
      end while (magnitude != 0);
      if (negative) begin
        place_character(CH_MINUS, 1'b0);
      end
      for (int i = ndigits - 1; i >= 0; i--) begin
        if (digits[i] > 9) begin
          digit_char = 8'(ASCII_UPPER_A + digits[i] - 10);
        end else begin
          digit_char = 8'(ASCII_ZERO + digits[i]);
        end
        place_character(digit_char, i == 0);
      end
    end
    // The unused kind leaves the state alone and produces nothing.
  endfunction

  // Sends one console item. The sender works in bursts: at the start of each
  // burst it may idle before its item, and about a quarter of the bursts
  // follow on without any gap. Valid is only lowered when a gap is taken, so
  // back-to-back items keep it high across the transfer edge.
  task automatic push_console_item(input logic [1:0] k, input logic [7:0] ch,
                                   input logic [31:0] value);
    int gap;
    gap = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if ($urandom_range(0, 3) != 0) begin
        gap = $urandom_range(1, 8);
      end
    end
    burst_left--;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    kind      <= k;
    char_code <= ch;
    number    <= value;
    do @(posedge clk); while (!in_ready);
    predict_cell_events(k, ch, value);
  endtask

  // Holds off the sender until every expected transfer has arrived, then
  // lets the block run out any item that produces no output.
  task automatic wait_for_idle();
    in_valid <= 1'b0;
    while (expected_cells.size() != 0) @(posedge clk);
    repeat (IDLE_SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes the attribute register with a setup and an access cycle, then
  // reads it back. Only done while the block is idle.
  task automatic write_text_attribute(input logic [7:0] value);
    wait_for_idle();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_TEXT_ATTRIBUTE;
    pwdata  <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    attr_shadow = value;
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[7:0] !== value) begin
      report_mismatch("text_attribute read back", prdata[7:0], value);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Numbers for the random part: many short ones, some negative, the
  // extremes now and then, and the rest spread over the whole range.
  function automatic logic [31:0] pick_number();
    case ($urandom_range(0, 5))
      0: pick_number = 32'($urandom_range(0, 15));
      1: pick_number = 32'd0 - 32'($urandom_range(1, 300));
      2: begin
        case ($urandom_range(0, 3))
          0: pick_number = 32'h0000_0000;
          1: pick_number = 32'h8000_0000;
          2: pick_number = 32'h7FFF_FFFF;
          default: pick_number = 32'hFFFF_FFFF;
        endcase
      end
      default: pick_number = $urandom;
    endcase
  endfunction

  // Plain characters at the reset attribute: a letter, the lowest and the
  // highest byte, which are both written as cells, then newline and tab.
  task automatic test_plain_characters();
    push_console_item(KIND_CHAR, 8'h41, 32'd0);
    push_console_item(KIND_CHAR, 8'h00, 32'd0);
    push_console_item(KIND_CHAR, 8'hFF, 32'hFFFF_FFFF);
    push_console_item(KIND_CHAR, CH_NEWLINE, 32'd0);
    push_console_item(KIND_CHAR, CH_TAB, 32'd0);
  endtask

  // Number formatting: zero in both radixes, both extremes, upper case hex
  // letters, a negative hex value, and the unused kind, which must be dropped.
  task automatic test_number_formats();
    push_console_item(KIND_DEC, 8'h00, 32'd0);
    push_console_item(KIND_HEX, 8'h00, 32'd0);
    push_console_item(KIND_DEC, 8'h00, 32'h7FFF_FFFF);
    push_console_item(KIND_DEC, 8'h00, 32'h8000_0000);
    push_console_item(KIND_HEX, 8'h00, 32'h8000_0000);
    push_console_item(KIND_HEX, 8'h00, 32'h7FAB_CDEF);
    push_console_item(KIND_HEX, 8'h00, 32'hFFFF_FFE1);
    push_console_item(KIND_UNUSED, 8'hFF, 32'hFFFF_FFFF);
  endtask

  // Seven eleven-character numbers leave the cursor at column 77, so the
  // ten digits that follow run over the row end and wrap mid-number.
  task automatic test_row_wrap();
    push_console_item(KIND_CHAR, CH_NEWLINE, 32'd0);
    repeat (7) push_console_item(KIND_DEC, 8'h00, 32'h8000_0000);
    push_console_item(KIND_DEC, 8'h00, 32'h7FFF_FFFF);
  endtask

  // General mix of characters and numbers, with some unused-kind noise that
  // does not count toward the item total.
  task automatic test_random_mix(input int count);
    int         sent;
    int         roll;
    logic [1:0] k;
    logic [7:0] ch;
    sent = 0;
    while (sent < count) begin
      roll = $urandom_range(0, 99);
      ch = 8'($urandom);
      if (roll < 30) begin
        k = KIND_CHAR;
      end else if (roll < 40) begin
        k = KIND_CHAR;
        ch = CH_NEWLINE;
      end else if (roll < 47) begin
        k = KIND_CHAR;
        ch = CH_TAB;
      end else if (roll < 72) begin
        k = KIND_DEC;
      end else if (roll < 94) begin
        k = KIND_HEX;
      end else begin
        k = KIND_UNUSED;
      end
      push_console_item(k, ch, pick_number());
      if (k != KIND_UNUSED) begin
        sent++;
      end
    end
  endtask

  // Heavy on newlines and tabs so the cursor walks down the screen quickly:
  // this drives tab overflow at the row end and clears the screen once the
  // last row is passed.
  task automatic test_console_scroll(input int count);
    int         roll;
    logic [1:0] k;
    logic [7:0] ch;
    for (int i = 0; i < count; i++) begin
      roll = $urandom_range(0, 99);
      k = KIND_CHAR;
      ch = 8'($urandom);
      if (roll < 40) begin
        ch = CH_NEWLINE;
      end else if (roll < 70) begin
        ch = CH_TAB;
      end else if (roll < 90) begin
        k = KIND_CHAR;
      end else begin
        k = KIND_DEC;
      end
      push_console_item(k, ch, pick_number());
    end
  endtask

  // The receiver switches between patterns at random intervals: always
  // ready, random, a fixed duty cycle, and long stalls with short openings.
  always @(posedge clk) begin
    if (rx_mode_left == 0) begin
      rx_mode = $urandom_range(0, 3);
      rx_mode_left = $urandom_range(100, 300);
    end
    rx_mode_left--;
    rx_tick++;
    case (rx_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (rx_tick % 7) >= 3;
      default: begin
        if (rx_hold == 0) begin
          rx_low = !rx_low;
          rx_hold = rx_low ? $urandom_range(8, 24) : $urandom_range(1, 6);
        end
        rx_hold--;
        out_ready <= !rx_low;
      end
    endcase
  end

  // Every output transfer is checked field by field against the oldest
  // expectation. A transfer with nothing expected is a failure of its own.
  always @(posedge clk) begin
    cell_event_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_cells.size() == 0) begin
        report_mismatch("transfer with nothing expected, cell_index", cell_index, 0);
      end else begin
        want = expected_cells.pop_front();
        if (do_write !== want.do_write) report_mismatch("do_write", do_write, want.do_write);
        if (cell_index !== want.cell_index) begin
          report_mismatch("cell_index", cell_index, want.cell_index);
        end
        if (glyph !== want.glyph) report_mismatch("glyph", glyph, want.glyph);
        if (attribute !== want.attribute) begin
          report_mismatch("attribute", attribute, want.attribute);
        end
        if (clear_screen !== want.clear_screen) begin
          report_mismatch("clear_screen", clear_screen, want.clear_screen);
        end
        if (last !== want.last) report_mismatch("last", last, want.last);
      end
      results_checked++;
    end
  end

  // Counts cycles in which no transfer happens on any port.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // A block that stops moving ends the run.
  initial begin
    wait (quiet_cycles >= QUIET_LIMIT);
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    rst       = 1'b1;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    in_valid  = 1'b0;
    kind      = KIND_CHAR;
    char_code = '0;
    number    = '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    cursor_col  = 0;
    cursor_row  = 0;
    attr_shadow = ATTR_RESET;

    // The first phase runs on the attribute that reset leaves behind.
    test_plain_characters();
    write_text_attribute(8'hFF);
    test_number_formats();
    write_text_attribute(8'h00);
    test_row_wrap();
    write_text_attribute(8'($urandom));
    test_random_mix(50);
    // Let everything drain once in the middle of random traffic.
    wait_for_idle();
    test_random_mix(50);
    write_text_attribute(8'($urandom));
    test_console_scroll(50);

    wait_for_idle();
    if (expected_cells.size() != 0) begin
      report_mismatch("transfers never delivered", 0, expected_cells.size());
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
